// File: hdl/tagged_varint_stream_decoder_macros.svh
// Assertion macros shared by the decoder modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef TAGGED_VARINT_STREAM_DECODER_MACROS_SVH
`define TAGGED_VARINT_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define TVSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvsd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TVSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvsd assertion failed");

`else

`define TVSD_ASSERT_SAME(lbl, ante, cons)
`define TVSD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: hdl/tvsd_pkg.sv
package tvsd_pkg;

  // Default limit on the number of extra bytes after an integer header.
  localparam int TVSD_MAX_EXTRA_BYTES = 8;
  // Default depth of the queue between the parser and the output stage.
  localparam int TVSD_QUEUE_DEPTH = 2;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_TAG,
    PH_CHAR,
    PH_HEADER,
    PH_EXTRA,
    PH_STRING
  } phase_t;

  // Result kinds.
  localparam logic [2:0] K_BOOL  = 3'd0;
  localparam logic [2:0] K_CHAR  = 3'd1;
  localparam logic [2:0] K_SHORT = 3'd2;
  localparam logic [2:0] K_INT   = 3'd3;
  localparam logic [2:0] K_LONG  = 3'd4;
  localparam logic [2:0] K_SLEN  = 3'd5;
  localparam logic [2:0] K_SCHAR = 3'd6;
  localparam logic [2:0] K_NONE  = 3'd7;

  // Error codes.
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_TAG   = 2'd1;
  localparam logic [1:0] ERR_RANGE = 2'd2;
  localparam logic [1:0] ERR_LEN   = 2'd3;

  // Tag bytes.
  localparam logic [7:0] TAG_TRUE  = 8'h74; // 't'
  localparam logic [7:0] TAG_FALSE = 8'h66; // 'f'
  localparam logic [7:0] TAG_CHAR  = 8'h63; // 'c'
  localparam logic [7:0] TAG_SHORT = 8'h73; // 's'
  localparam logic [7:0] TAG_INT   = 8'h69; // 'i'
  localparam logic [7:0] TAG_LONG  = 8'h6c; // 'l'
  localparam logic [7:0] TAG_STR   = 8'h53; // 'S'

  // One decoded result before the range check.
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [63:0] value;
    logic [1:0]         err;
  } result_t;

  // A result together with its valid flag, used at both ends of the queue.
  typedef struct packed {
    logic    valid;
    result_t data;
  } q_entry_t;

endpackage

// File: hdl/tvsd_if.sv
// Byte channel into the decoder.
interface tvsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

// Result channel out of the decoder.
interface tvsd_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [63:0] value;
  logic [1:0]         error_code;

  modport source(output valid, output kind, output value, output error_code, input ready);
  modport sink(input valid, input kind, input value, input error_code, output ready);
endinterface

// File: hdl/tvsd_front.sv
`include "tagged_varint_stream_decoder_macros.svh"

module tvsd_front #(
  parameter int MAX_EXTRA_BYTES = tvsd_pkg::TVSD_MAX_EXTRA_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  tvsd_in_if.sink            in_ch,
  input  logic               q_full,
  output tvsd_pkg::q_entry_t push
);
  import tvsd_pkg::*;

  localparam logic [3:0] MAX_C = 4'(MAX_EXTRA_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic [3:0]  brem_r, brem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] chars_r, chars_nxt;

  logic        fire;
  logic [7:0]  b;
  logic [3:0]  hdr_cnt;
  logic        hdr_bad;
  logic [63:0] hdr_val;
  logic [63:0] ext_val;
  logic        ext_last;
  logic [63:0] fin_val;
  logic        str_go;

  // A byte is taken whenever the queue has room for a possible result.
  assign in_ch.ready = !q_full;
  assign fire        = in_ch.valid && !q_full;
  assign b           = in_ch.data_byte;

  // Header and extra-byte arithmetic.
  assign hdr_cnt  = b[7:4];
  assign hdr_bad  = hdr_cnt > MAX_C;
  assign hdr_val  = {{60{b[3]}}, b[3:0]};
  assign ext_val  = {acc_r[55:0], b};
  assign ext_last = brem_r == 4'd1;
  assign fin_val  = (phase_r == PH_HEADER) ? hdr_val : ext_val;
  // A positive string length moves the parser into the string phase.
  assign str_go   = (kind_r == K_SLEN) && (fin_val != 64'd0) && !fin_val[63];

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      unique case (phase_r)
        PH_TAG: begin
          unique case (b) inside
            TAG_CHAR:                             phase_nxt = PH_CHAR;
            TAG_SHORT, TAG_INT, TAG_LONG, TAG_STR: phase_nxt = PH_HEADER;
            default:                              phase_nxt = PH_TAG;
          endcase
        end
        PH_CHAR: phase_nxt = PH_TAG;
        PH_HEADER: begin
          if (hdr_bad) begin
            phase_nxt = PH_TAG;
          end else if (hdr_cnt == 4'd0) begin
            phase_nxt = str_go ? PH_STRING : PH_TAG;
          end else begin
            phase_nxt = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          if (ext_last) begin
            phase_nxt = str_go ? PH_STRING : PH_TAG;
          end
        end
        PH_STRING: begin
          if (chars_r == 64'd1) begin
            phase_nxt = PH_TAG;
          end
        end
        default: phase_nxt = PH_TAG;
      endcase
    end
  end

  // Datapath updates and the request pushed into the queue.
  always_comb begin
    kind_nxt   = kind_r;
    brem_nxt   = brem_r;
    acc_nxt    = acc_r;
    chars_nxt  = chars_r;
    push       = '0;
    if (fire) begin
      unique case (phase_r)
        PH_TAG: begin
          unique case (b) inside
            TAG_TRUE: begin
              push.valid      = 1'b1;
              push.data.kind  = K_BOOL;
              push.data.value = 64'sd1;
              push.data.err   = ERR_OK;
            end
            TAG_FALSE: begin
              push.valid      = 1'b1;
              push.data.kind  = K_BOOL;
              push.data.value = 64'sd0;
              push.data.err   = ERR_OK;
            end
            TAG_CHAR:  kind_nxt = K_CHAR;
            TAG_SHORT: kind_nxt = K_SHORT;
            TAG_INT:   kind_nxt = K_INT;
            TAG_LONG:  kind_nxt = K_LONG;
            TAG_STR:   kind_nxt = K_SLEN;
            default: begin
              push.valid      = 1'b1;
              push.data.kind  = K_NONE;
              push.data.value = {56'd0, b};
              push.data.err   = ERR_TAG;
            end
          endcase
        end
        PH_CHAR: begin
          push.valid      = 1'b1;
          push.data.kind  = K_CHAR;
          push.data.value = {56'd0, b};
          push.data.err   = ERR_OK;
        end
        PH_HEADER: begin
          if (hdr_bad) begin
            push.valid      = 1'b1;
            push.data.kind  = kind_r;
            push.data.value = 64'sd0;
            push.data.err   = ERR_LEN;
          end else begin
            acc_nxt  = hdr_val;
            brem_nxt = hdr_cnt;
            if (hdr_cnt == 4'd0) begin
              push.valid      = 1'b1;
              push.data.kind  = kind_r;
              push.data.value = fin_val;
              push.data.err   = ERR_OK;
              if (str_go) begin
                chars_nxt = fin_val;
              end
            end
          end
        end
        PH_EXTRA: begin
          acc_nxt  = ext_val;
          brem_nxt = brem_r - 4'd1;
          if (ext_last) begin
            push.valid      = 1'b1;
            push.data.kind  = kind_r;
            push.data.value = fin_val;
            push.data.err   = ERR_OK;
            if (str_go) begin
              chars_nxt = fin_val;
            end
          end
        end
        PH_STRING: begin
          chars_nxt       = chars_r - 64'd1;
          push.valid      = 1'b1;
          push.data.kind  = K_SCHAR;
          push.data.value = {56'd0, b};
          push.data.err   = ERR_OK;
        end
        default: ;
      endcase
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      kind_r  <= K_BOOL;
      brem_r  <= 4'd0;
      acc_r   <= 64'd0;
      chars_r <= 64'd0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      brem_r  <= brem_nxt;
      acc_r   <= acc_nxt;
      chars_r <= chars_nxt;
    end
  end

  // An extra-byte phase always has bytes left, and a string phase characters left.
  `TVSD_ASSERT_SAME(a_extra_left, phase_r == PH_EXTRA, brem_r != 4'd0)
  `TVSD_ASSERT_SAME(a_chars_left, phase_r == PH_STRING, chars_r != 64'd0)
  // A header is only expected after an integer or string tag.
  `TVSD_ASSERT_SAME(a_header_kind, phase_r == PH_HEADER,
    kind_r == K_SHORT || kind_r == K_INT || kind_r == K_LONG || kind_r == K_SLEN)

endmodule

// File: hdl/tvsd_queue.sv
`include "tagged_varint_stream_decoder_macros.svh"

module tvsd_queue #(
  parameter int DEPTH = tvsd_pkg::TVSD_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tvsd_pkg::q_entry_t push,
  input  logic               pop,
  output logic               full,
  output tvsd_pkg::q_entry_t head
);
  import tvsd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

  result_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push;
  logic            do_pop;

  assign full       = count_r == DEPTH_C;
  assign do_push    = push.valid;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = count_r != '0;
  assign head.data  = mem_r[rd_ptr_r];

  // Pointer and fill-count updates.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.data;
    end
  end

  // The parser never pushes into a full queue.
  `TVSD_ASSERT_SAME(a_no_overflow, push.valid, !full)
  `TVSD_ASSERT_SAME(a_count_bound, 1'b1, count_r <= DEPTH_C)
  `TVSD_ASSERT_SAME(a_empty_ptrs, count_r == '0, wr_ptr_r == rd_ptr_r)

endmodule

// File: hdl/tvsd_back.sv
`include "tagged_varint_stream_decoder_macros.svh"

module tvsd_back (
  input  logic               clk,
  input  logic               rst_n,
  input  tvsd_pkg::q_entry_t head,
  output logic               pop,
  tvsd_out_if.source         out_ch
);
  import tvsd_pkg::*;

  logic               valid_r;
  logic [2:0]         kind_r;
  logic signed [63:0] value_r;
  logic [1:0]         err_r;

  logic take;
  logic s16_ok;
  logic s32_ok;
  logic range_bad;

  // The output register loads when it is empty or its result is being taken.
  assign take = !valid_r || out_ch.ready;
  assign pop  = head.valid && take;

  // Signed range checks for short and int results.
  assign s16_ok    = (&head.data.value[63:15]) || !(|head.data.value[63:15]);
  assign s32_ok    = (&head.data.value[63:31]) || !(|head.data.value[63:31]);
  assign range_bad = (head.data.err == ERR_OK) &&
                     (((head.data.kind == K_SHORT) && !s16_ok) ||
                      ((head.data.kind == K_INT) && !s32_ok));

  // Output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= head.valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r  <= head.data.kind;
      value_r <= range_bad ? 64'sd0 : head.data.value;
      err_r   <= range_bad ? ERR_RANGE : head.data.err;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.value      = value_r;
  assign out_ch.error_code = err_r;

  // Range/length errors are zeroed, OK shorts fit 16 bits, booleans are 0 or 1.
  `TVSD_ASSERT_SAME(a_err_zero, valid_r && (err_r == ERR_RANGE || err_r == ERR_LEN),
    value_r == 64'sd0)
  `TVSD_ASSERT_SAME(a_short_fits, valid_r && kind_r == K_SHORT && err_r == ERR_OK,
    (&value_r[63:15]) || !(|value_r[63:15]))
  `TVSD_ASSERT_SAME(a_bool_bit, valid_r && kind_r == K_BOOL, value_r[63:1] == 63'd0)

endmodule

// File: hdl/tagged_varint_stream_decoder.sv
// Tagged varint stream decoder: takes one stream byte per request and returns one
// result request for each boolean, char, integer, string length, string character and
// unknown tag. Bytes are accepted at one per cycle; the input stalls only when the
// two-entry result queue is full, which happens when the result consumer holds off
// while three results are pending, one in the output register and two in the queue.
// The input is ready again in the cycle after the consumer takes a result from that
// full state. A result enters the queue at the edge that accepts its last byte and
// moves to the output register once that register is empty or its result is taken.
// Header bytes followed by extra bytes and non-final extra bytes produce no result.
// Short and int values outside their signed range get a range error and value zero.
module tagged_varint_stream_decoder #(
  parameter int MAX_EXTRA_BYTES = tvsd_pkg::TVSD_MAX_EXTRA_BYTES,
  parameter int QUEUE_DEPTH     = tvsd_pkg::TVSD_QUEUE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  tvsd_in_if.sink    in_ch,
  tvsd_out_if.source out_ch
);
  import tvsd_pkg::*;

  q_entry_t push;
  q_entry_t head;
  logic     q_full;
  logic     pop;

  // Parser: classifies tags and assembles integers.
  tvsd_front #(
    .MAX_EXTRA_BYTES(MAX_EXTRA_BYTES)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .q_full(q_full),
    .push  (push)
  );

  // Result queue between parser and output stage.
  tvsd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (push),
    .pop  (pop),
    .full (q_full),
    .head (head)
  );

  // Output stage: range check and result register.
  tvsd_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .out_ch(out_ch)
  );

endmodule
